/* sv/tfb_pkg.sv */
package tfb_pkg;

	localparam int HEADER_BYTES = 4;
	localparam int LEN_W = 16;
	localparam int POS_W = 17;
	localparam int CNT_W = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QIDX_W = 2;
	localparam int QCNT_W = 3;
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 48;
	localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 16'd16384;
	localparam logic [POS_W-1:0] LEN17_MAX = 17'h1FFFF;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_HDR  = 2'd1,
		KIND_LONG = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [31:0]        data;
		logic [POS_W-1:0]   pos;
		logic [CNT_W-1:0]   last_idx;
		logic               last_end;
		logic [LEN_W-1:0]   wrap;
		logic [POS_W-1:0]   total;
	} cmd_t;

endpackage

/* sv/tfb_queue.sv */
module tfb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tfb_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output tfb_pkg::cmd_t head
);
	import tfb_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QIDX_W-1:0] wr_ptr_q;
	logic [QIDX_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");
`endif

endmodule

/* sv/tfb_front.sv */
module tfb_front #(
	parameter int unsigned ALIGN_BYTES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tfb_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tfb_pkg::LEN_W-1:0]      cfg_data,
	input  logic                           q_full,
	output logic                           push,
	output tfb_pkg::cmd_t                  push_cmd
);
	import tfb_pkg::*;

	localparam int SH = POS_W + $clog2(ALIGN_BYTES);
	localparam int PW = SH + POS_W;
	localparam logic [POS_W:0] RECIP = (POS_W + 1)'((2 ** SH + ALIGN_BYTES - 1) / ALIGN_BYTES);

	typedef enum logic [3:0] {
		ST_RUN = 4'b0001,
		ST_DIV = 4'b0010,
		ST_MUL = 4'b0100,
		ST_FIN = 4'b1000
	} st_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_HW   = 4'b0010,
		PH_SW   = 4'b0100,
		PH_DROP = 4'b1000
	} ph_t;

	st_t              st_q;
	ph_t              phase_q;
	logic [LEN_W-1:0] hw_left_q;
	logic [LEN_W-1:0] sw_left_q;
	logic [POS_W-1:0] pos_q;
	logic [LEN_W-1:0] wrap_q;
	logic [POS_W-1:0] sw_start_q;
	logic [POS_W-1:0] total_q;
	logic [LEN_W-1:0] max_q;
	logic [LEN_W-1:0] hw_in_q;
	logic [LEN_W-1:0] sw_in_q;
	logic [POS_W-1:0] q1_q;
	logic [POS_W-1:0] q2_q;
	logic [POS_W-1:0] swoff_q;
	logic [POS_W-1:0] swal_q;

	logic             accept;
	logic [LEN_W-1:0] in_hw;
	logic [LEN_W-1:0] in_sw;
	logic [LEN_W-1:0] in_wrap;
	logic [7:0]       in_byte;
	logic [POS_W-1:0] x1;
	logic [POS_W-1:0] x2;
	logic [PW-1:0]    prod1;
	logic [PW-1:0]    prod2;
	logic [POS_W:0]   total_w;
	logic [POS_W-1:0] total_sat;
	logic             too_long_w;
	logic [LEN_W-1:0] seg;
	logic [LEN_W-1:0] hw_dec;
	logic [LEN_W-1:0] sw_dec;
	logic [POS_W-1:0] pos_inc;
	logic [POS_W-1:0] pad;
	logic             drop_done;
	logic             fin_go;
	logic             hdr_empty;

	assign s_tready = (st_q == ST_RUN) && !q_full;
	assign accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign in_hw = s_tdata[15:0];
	assign in_sw = s_tdata[31:16];
	assign in_wrap = s_tdata[47:32];
	assign in_byte = s_tdata[55:48];

	assign x1 = POS_W'(HEADER_BYTES + ALIGN_BYTES - 1) + {1'b0, hw_in_q};
	assign x2 = POS_W'(ALIGN_BYTES - 1) + {1'b0, sw_in_q};
	assign prod1 = PW'(x1) * PW'(RECIP);
	assign prod2 = PW'(x2) * PW'(RECIP);

	assign total_w = {1'b0, swoff_q} + {1'b0, swal_q};
	assign total_sat = total_w[POS_W] ? LEN17_MAX : total_w[POS_W-1:0];
	assign too_long_w = total_w > {2'b00, max_q};
	assign seg = swoff_q[LEN_W-1:0] + sw_in_q;
	assign hdr_empty = (hw_in_q == '0) && (sw_in_q == '0);

	assign hw_dec = hw_left_q - 1'b1;
	assign sw_dec = sw_left_q - 1'b1;
	assign pos_inc = pos_q + 1'b1;
	assign pad = total_q - pos_inc;
	assign drop_done = (hw_left_q != '0) ? (hw_left_q == 16'd1 && sw_left_q == '0)
		: (sw_left_q <= 16'd1);
	assign fin_go = (st_q == ST_FIN) && !q_full;

	always_comb begin
		push = 1'b0;
		push_cmd.kind = KIND_DATA;
		push_cmd.data = {24'd0, in_byte};
		push_cmd.pos = pos_q;
		push_cmd.last_idx = '0;
		push_cmd.last_end = 1'b0;
		push_cmd.wrap = wrap_q;
		push_cmd.total = total_q;
		if (fin_go) begin
			push = 1'b1;
			push_cmd.total = total_sat;
			push_cmd.pos = '0;
			if (too_long_w) begin
				push_cmd.kind = KIND_LONG;
				push_cmd.data = '0;
				push_cmd.last_end = 1'b1;
			end else begin
				push_cmd.kind = KIND_HDR;
				push_cmd.data = {hw_in_q, seg};
				push_cmd.last_idx = CNT_W'(HEADER_BYTES - 1);
				push_cmd.last_end = hdr_empty;
			end
		end else if (accept && s_tuser) begin
			unique case (phase_q)
				PH_HW: begin
					push = 1'b1;
					push_cmd.last_end = (hw_dec == '0) && (sw_left_q == '0);
				end
				PH_SW: begin
					push = 1'b1;
					if (sw_dec == '0) begin
						push_cmd.last_idx = CNT_W'(pad);
						push_cmd.last_end = 1'b1;
					end
				end
				PH_IDLE, PH_DROP: begin
					push = 1'b0;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RUN;
			phase_q <= PH_IDLE;
			hw_left_q <= '0;
			sw_left_q <= '0;
			pos_q <= '0;
			wrap_q <= '0;
			sw_start_q <= '0;
			total_q <= '0;
			max_q <= MAX_FRAME_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
			unique case (st_q)
				ST_RUN: begin
					if (accept && !s_tuser) begin
						wrap_q <= in_wrap;
						st_q <= ST_DIV;
					end else if (accept) begin
						unique case (phase_q)
							PH_DROP: begin
								if (hw_left_q != '0) begin
									hw_left_q <= hw_dec;
								end else if (sw_left_q != '0) begin
									sw_left_q <= sw_dec;
								end
								if (drop_done) begin
									phase_q <= PH_IDLE;
								end
							end
							PH_HW: begin
								hw_left_q <= hw_dec;
								if (hw_dec == '0 && sw_left_q == '0) begin
									phase_q <= PH_IDLE;
									pos_q <= '0;
								end else if (hw_dec == '0) begin
									phase_q <= PH_SW;
									pos_q <= sw_start_q;
								end else begin
									pos_q <= pos_inc;
								end
							end
							PH_SW: begin
								sw_left_q <= sw_dec;
								if (sw_dec != '0) begin
									pos_q <= pos_inc;
								end else begin
									phase_q <= PH_IDLE;
									pos_q <= '0;
								end
							end
							PH_IDLE: begin
								phase_q <= PH_IDLE;
							end
							default: begin
								phase_q <= PH_IDLE;
							end
						endcase
					end
				end
				ST_DIV: begin
					st_q <= ST_MUL;
				end
				ST_MUL: begin
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!q_full) begin
						st_q <= ST_RUN;
						sw_start_q <= swoff_q;
						total_q <= total_sat;
						hw_left_q <= hw_in_q;
						sw_left_q <= sw_in_q;
						if (too_long_w) begin
							phase_q <= hdr_empty ? PH_IDLE : PH_DROP;
							pos_q <= '0;
						end else if (hw_in_q != '0) begin
							phase_q <= PH_HW;
							pos_q <= POS_W'(HEADER_BYTES);
						end else if (sw_in_q != '0) begin
							phase_q <= PH_SW;
							pos_q <= swoff_q;
						end else begin
							phase_q <= PH_IDLE;
							pos_q <= '0;
						end
					end
				end
				default: begin
					st_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !s_tuser) begin
			hw_in_q <= in_hw;
			sw_in_q <= in_sw;
		end
		if (st_q == ST_DIV) begin
			q1_q <= prod1[SH +: POS_W];
			q2_q <= prod2[SH +: POS_W];
		end
		if (st_q == ST_MUL) begin
			swoff_q <= POS_W'(q1_q * POS_W'(ALIGN_BYTES));
			swal_q <= POS_W'(q2_q * POS_W'(ALIGN_BYTES));
		end
	end

`ifndef SYNTHESIS
	a_start_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser) |=> !s_tready)
		else $error("input taken during start computation");
`endif

endmodule

/* sv/tfb_back.sv */
module tfb_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           head_valid,
	input  tfb_pkg::cmd_t                  head,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tfb_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                           m_tlast,
	output logic                           m_tuser
);
	import tfb_pkg::*;

	logic [CNT_W-1:0] idx_q;
	logic [POS_W-1:0] run_pos_q;
	logic             valid_q;
	logic [7:0]       byte_q;
	logic             sel_q;
	logic [POS_W-1:0] off_q;
	logic             end_q;
	logic             long_q;
	logic [POS_W-1:0] len_q;

	logic             adv;
	logic             is_last;
	logic [POS_W-1:0] cur_pos;
	logic [POS_W-1:0] wrap_ext;
	logic             sel_w;
	logic [POS_W-1:0] off_w;
	logic [7:0]       byte_w;

	assign adv = head_valid && (!valid_q || m_tready);
	assign is_last = (idx_q == head.last_idx);
	assign pop = adv && is_last;
	assign cur_pos = (idx_q == '0) ? head.pos : run_pos_q;
	assign wrap_ext = {1'b0, head.wrap};

	always_comb begin
		sel_w = 1'b0;
		off_w = cur_pos;
		byte_w = '0;
		unique case (head.kind)
			KIND_HDR: begin
				byte_w = head.data[{idx_q[1:0], 3'b000} +: 8];
				sel_w = cur_pos >= wrap_ext;
				off_w = sel_w ? cur_pos - wrap_ext : cur_pos;
			end
			KIND_DATA: begin
				byte_w = (idx_q == '0) ? head.data[7:0] : 8'd0;
				sel_w = cur_pos >= wrap_ext;
				off_w = sel_w ? cur_pos - wrap_ext : cur_pos;
			end
			KIND_LONG: begin
				off_w = '0;
			end
			default: begin
				off_w = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (adv) begin
			valid_q <= 1'b1;
			idx_q <= is_last ? '0 : idx_q + 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			run_pos_q <= cur_pos + 1'b1;
			byte_q <= byte_w;
			sel_q <= sel_w;
			off_q <= off_w;
			end_q <= is_last && head.last_end;
			long_q <= (head.kind == KIND_LONG);
			len_q <= head.total;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {5'd0, len_q, off_q, sel_q, byte_q};
	assign m_tlast = end_q;
	assign m_tuser = long_q;

`ifndef SYNTHESIS
	a_long_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && m_tdata[25:0] == 26'd0))
		else $error("oversize result not a lone empty end");
`endif

endmodule

/* sv/tx_frame_builder_split.sv */
// Transmit frame builder. Start items (s_tuser 0) carry hardware length,
// software length and the room before the ring wraps; data items (s_tuser 1)
// carry one payload byte each, hardware bytes first, then software bytes.
// Each result on the master side is one frame byte with its space and offset:
// four header bytes, the payload, then zero padding to the alignment.
// m_tlast marks the last byte of a frame; m_tuser marks the single result of
// an oversize frame, whose payload items are then consumed silently.
// cfg_* writes max_frame_bytes; it is always ready and should be written idle.
// Throughput: one data item per cycle while the queue has room. A start item
// holds the input low after its transfer through the length/alignment sequencer
// (divide, multiply, compare, the last waiting for queue room) and yields four
// header transfers, or one if oversize; the last software byte yields up to
// ALIGN_BYTES transfers, one per cycle from the output stage unless it stalls.
// A data item's result passes the command queue and the output register; a
// start item's first header byte passes the DIV, MUL and FIN states before them.
// A four-entry command queue parts the input side from the output stage, so
// a stalled receiver only stops input once the queue fills.
// Reset clears the queue, the output stage and all frame state, and sets
// max_frame_bytes to 16384.
module tx_frame_builder_split #(
	parameter int unsigned ALIGN_BYTES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// hw_length[15:0], sw_length[31:16], first_space_bytes[47:32], data_byte[55:48]
	input  logic [tfb_pkg::S_TDATA_W-1:0]  s_tdata,
	// req_type[0]
	input  logic                           s_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tfb_pkg::LEN_W-1:0]      cfg_data,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_byte[7:0], space_select[8], space_offset[25:9], frame_length[42:26]
	output logic [tfb_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                           m_tlast,
	// too_long[0]
	output logic                           m_tuser
);
	import tfb_pkg::*;

	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head;

	tfb_front #(
		.ALIGN_BYTES(ALIGN_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	tfb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	tfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule
